### rtl/core/rftc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rftc_pkg: shared types and constants for the receive frame collector
// Item kinds, register indexes, field widths and the result record passed
// from the collector core to the output stage.
// ----------------------------------------------------------------------------
package rftc_pkg;

    localparam int KIND_W       = 2;
    localparam int DATA_W       = 8;
    localparam int RIDX_W       = 6;
    localparam int COUNT_W      = 7;
    localparam int TICK_W       = 16;
    localparam int CFG_IDX_W    = 2;

    localparam int BUF_DEPTH_DEFAULT = 64;

    localparam logic [TICK_W-1:0] FIRST_WAIT_RESET = 16'd250;

    typedef enum logic [KIND_W-1:0] {
        KIND_ARM  = 2'd0,
        KIND_BYTE = 2'd1,
        KIND_TICK = 2'd2,
        KIND_READ = 2'd3
    } rftc_kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_WAIT   = 2'd0,
        CFG_GAP        = 2'd1,
        CFG_FIRST_WAIT = 2'd2
    } rftc_cfg_idx_t;

    // Result of one item as it leaves the collector core; the buffer read
    // data travels beside it in the memory output register.
    typedef struct packed {
        logic                frame_done;
        logic [COUNT_W-1:0]  byte_count;
        logic                rd_hit;
        logic                forward_valid;
        logic [DATA_W-1:0]   forward_data;
    } rftc_result_t;

endpackage

### rtl/core/rftc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rftc_if: valid/ready channels of the receive frame collector
// Input item channel, result channel and register write channel.
// ----------------------------------------------------------------------------
interface rftc_item_if;
    logic                      valid;
    logic                      ready;
    logic [rftc_pkg::KIND_W-1:0] kind;
    logic [rftc_pkg::DATA_W-1:0] rx_data;
    logic [rftc_pkg::RIDX_W-1:0] read_index;

    modport source (output valid, kind, rx_data, read_index, input ready);
    modport sink   (input valid, kind, rx_data, read_index, output ready);
endinterface

interface rftc_result_if;
    logic                         valid;
    logic                         ready;
    logic                         frame_done;
    logic [rftc_pkg::COUNT_W-1:0] byte_count;
    logic [rftc_pkg::DATA_W-1:0]  read_data;
    logic                         forward_valid;
    logic [rftc_pkg::DATA_W-1:0]  forward_data;

    modport source (output valid, frame_done, byte_count, read_data,
                    forward_valid, forward_data, input ready);
    modport sink   (input valid, frame_done, byte_count, read_data,
                    forward_valid, forward_data, output ready);
endinterface

interface rftc_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [rftc_pkg::CFG_IDX_W-1:0] index;
    logic [rftc_pkg::TICK_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/rftc_collector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rftc_collector: frame state, timers and byte buffer
// Updates the frame state for each accepted item and registers its result,
// including a registered read of the byte buffer.
// ----------------------------------------------------------------------------
module rftc_collector #(
    parameter int BUF_DEPTH = rftc_pkg::BUF_DEPTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic [rftc_pkg::KIND_W-1:0]   kind,
    input  logic [rftc_pkg::DATA_W-1:0]   rx_data,
    input  logic [rftc_pkg::RIDX_W-1:0]   read_index,
    input  logic [rftc_pkg::TICK_W-1:0]   max_wait_ticks,
    input  logic [rftc_pkg::TICK_W-1:0]   gap_ticks,
    input  logic [rftc_pkg::TICK_W-1:0]   first_wait_ticks,
    output rftc_pkg::rftc_result_t        res,
    output logic [rftc_pkg::DATA_W-1:0]   rd_data
);
    import rftc_pkg::*;

    localparam int IDX_W = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam int CNT_W = $clog2(BUF_DEPTH + 1);
    localparam int CMP_W = (CNT_W > RIDX_W) ? CNT_W : RIDX_W;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(BUF_DEPTH);

    logic                armed_reg, armed_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [TICK_W-1:0]   gap_reg, gap_next;
    logic [TICK_W-1:0]   total_reg, total_next;
    logic [TICK_W-1:0]   gap_dec, total_dec;
    logic                wr_en;
    logic                fwd_v;
    logic                rd_hit;
    rftc_kind_t          kind_e;
    rftc_result_t        res_reg;
    logic [DATA_W-1:0]   rd_reg;
    logic [DATA_W-1:0]   mem [BUF_DEPTH];

    assign kind_e    = rftc_kind_t'(kind);
    assign gap_dec   = (gap_reg != '0) ? gap_reg - TICK_W'(1) : gap_reg;
    assign total_dec = (total_reg != '0) ? total_reg - TICK_W'(1) : total_reg;

    // Entries at or above the fill count are not cleared by an arm; the read
    // is flagged as a miss so the output stage returns zero for them instead.
    assign rd_hit = (kind_e == KIND_READ) && (CMP_W'(read_index) < CMP_W'(count_reg));

    always_comb
    begin
        armed_next = armed_reg;
        done_next  = done_reg;
        count_next = count_reg;
        gap_next   = gap_reg;
        total_next = total_reg;
        wr_en      = 1'b0;
        fwd_v      = 1'b0;
        unique case (kind_e)
            KIND_ARM:
            begin
                armed_next = 1'b1;
                done_next  = 1'b0;
                count_next = '0;
                total_next = max_wait_ticks;
                gap_next   = (gap_ticks == '0) ? '0 : first_wait_ticks;
            end
            KIND_BYTE:
            begin
                if (armed_reg && !done_reg)
                begin
                    if (count_reg < DEPTH_CNT)
                    begin
                        if (gap_reg != '0)
                        begin
                            gap_next = gap_ticks;
                        end
                        wr_en      = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        done_next = 1'b1;
                    end
                end
                else
                begin
                    fwd_v = 1'b1;
                end
            end
            KIND_TICK:
            begin
                gap_next   = gap_dec;
                total_next = total_dec;
                if (gap_dec == TICK_W'(1) || total_dec == TICK_W'(1))
                begin
                    done_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
            gap_reg   <= '0;
            total_reg <= '0;
        end
        else if (accept)
        begin
            armed_reg <= armed_next;
            done_reg  <= done_next;
            count_reg <= count_next;
            gap_reg   <= gap_next;
            total_reg <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg.frame_done    <= done_next;
            res_reg.byte_count    <= COUNT_W'(count_next);
            res_reg.rd_hit        <= rd_hit;
            res_reg.forward_valid <= fwd_v;
            res_reg.forward_data  <= fwd_v ? rx_data : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && wr_en)
        begin
            mem[IDX_W'(count_reg)] <= rx_data;
        end
        if (accept)
        begin
            rd_reg <= mem[IDX_W'(read_index)];
        end
    end

    assign res     = res_reg;
    assign rd_data = rd_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("fill count beyond buffer depth");

    a_byte_stored: assert property (@(posedge clk) disable iff (!rst_n)
        accept && kind_e == KIND_BYTE && armed_reg && !done_reg && count_reg < DEPTH_CNT
        |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("captured byte did not advance the fill count");

    a_done_cleared_by_arm: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(done_reg) |-> $past(accept && kind_e == KIND_ARM))
        else $error("done cleared without an arm transaction");

endmodule

### rtl/core/receive_frame_timeout_collector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// receive_frame_timeout_collector: reply frame collector with gap timeout
// Collects received bytes into a frame buffer, ends the frame on an overall
// or inter-byte timeout or on overflow, and forwards bytes received while unarmed or done.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Contents
//  -------  ---------  ------------------------------------------------------
//  item     in         kind, rx_data, read_index (arm, byte, tick, read)
//  result   out        frame_done, byte_count, read_data, forward_valid/data
//  cfg      in         index, data (0 max wait, 1 gap, 2 first wait)
//
//  One item transaction is taken every cycle while item ready is high; its result
//  is registered in the core stage (result and buffer read registers) and then
//  in the output register. The state update itself is combinational logic.
//  After reset no clearing pass runs: buffer entries at or above the fill count
//  read as zero, so the block takes items as soon as reset is released.
//  When the result side stalls, one result waits in the output register and
//  one in the core stage; item ready drops only when both are occupied.
//  Configuration transactions are always accepted.
//
module receive_frame_timeout_collector #(
    parameter int BUF_DEPTH = rftc_pkg::BUF_DEPTH_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    rftc_item_if.sink       item,
    rftc_result_if.source   result,
    rftc_cfg_if.sink        cfg
);
    import rftc_pkg::*;

    logic [TICK_W-1:0] max_wait_reg;
    logic [TICK_W-1:0] gap_reg;
    logic [TICK_W-1:0] first_wait_reg;

    logic              accept;
    logic              stage_valid_reg;
    logic              stage_move;
    logic              out_valid_reg;
    rftc_result_t      stage_res;
    logic [DATA_W-1:0] stage_rd;

    logic              out_done_reg;
    logic [COUNT_W-1:0] out_count_reg;
    logic [DATA_W-1:0] out_rd_reg;
    logic              out_fwd_v_reg;
    logic [DATA_W-1:0] out_fwd_d_reg;

    // Register writes: an index past the list is simply dropped.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_wait_reg   <= '0;
            gap_reg        <= '0;
            first_wait_reg <= FIRST_WAIT_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (rftc_cfg_idx_t'(cfg.index))
                CFG_MAX_WAIT:   max_wait_reg   <= cfg.data;
                CFG_GAP:        gap_reg        <= cfg.data;
                CFG_FIRST_WAIT: first_wait_reg <= cfg.data;
                default:
                begin
                end
            endcase
        end
    end

    // The core stage advances into the output register whenever that register
    // is empty or being drained this cycle.
    assign stage_move = stage_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !stage_valid_reg || stage_move;
    assign accept     = item.valid && item.ready;

    rftc_collector #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_collector (
        .clk              (clk),
        .rst_n            (rst_n),
        .accept           (accept),
        .kind             (item.kind),
        .rx_data          (item.rx_data),
        .read_index       (item.read_index),
        .max_wait_ticks   (max_wait_reg),
        .gap_ticks        (gap_reg),
        .first_wait_ticks (first_wait_reg),
        .res              (stage_res),
        .rd_data          (stage_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                stage_valid_reg <= 1'b1;
            end
            else if (stage_move)
            begin
                stage_valid_reg <= 1'b0;
            end

            if (stage_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Buffer data is used only when the read hit a written entry.
    always_ff @(posedge clk)
    begin
        if (stage_move)
        begin
            out_done_reg  <= stage_res.frame_done;
            out_count_reg <= stage_res.byte_count;
            out_rd_reg    <= stage_res.rd_hit ? stage_rd : '0;
            out_fwd_v_reg <= stage_res.forward_valid;
            out_fwd_d_reg <= stage_res.forward_data;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.frame_done    = out_done_reg;
    assign result.byte_count    = out_count_reg;
    assign result.read_data     = out_rd_reg;
    assign result.forward_valid = out_fwd_v_reg;
    assign result.forward_data  = out_fwd_d_reg;

    a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !item.ready |-> stage_valid_reg && out_valid_reg && !result.ready)
        else $error("item channel stalled with a free result slot");

    a_stage_feeds_output: assert property (@(posedge clk) disable iff (!rst_n)
        stage_move |=> out_valid_reg)
        else $error("core stage advanced without filling the output register");

    a_no_lost_result: assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid_reg && !stage_move |=> stage_valid_reg)
        else $error("waiting core result dropped");

endmodule
